// ===== sv/crv_pkg.sv =====
// ----------------------------------------------------------------------------
// crv_pkg: shared types and constants
// holds the request and status codes, register indexes and the queue item
// layouts used between the front end, the back end and the top level
// ----------------------------------------------------------------------------
package crv_pkg;

  localparam int unsigned DUR_W   = 40;
  localparam int unsigned LB_W    = 5;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned TIME_W  = 63;
  localparam int unsigned VOL_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LOG_W   = 25;   // 5 integer bits, 20 fraction bits
  localparam int unsigned LOG_FRAC = 20;

  // round(ln2 * year_ns / 4), year of 365 days
  localparam logic [63:0] LN2_NSY_Q = 64'd5464772371534609;

  localparam logic [DUR_W-1:0] DUR_RESET = 40'd60000000000;
  localparam logic [LB_W-1:0]  LB_RESET  = 5'd20;

  localparam logic REQ_TRADE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK = 2'd1;

  typedef enum logic [1:0] {
    ST_TAKEN  = 2'd0,
    ST_REJECT = 2'd1,
    ST_READY  = 2'd2,
    ST_SHORT  = 2'd3
  } status_e;

  typedef struct packed {
    logic               evaluate;
    logic [PRICE_W-1:0] price;
    logic [TIME_W-1:0]  start;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [VOL_W-1:0]   vol;
  } res_t;

endpackage

// ===== sv/crv_fifo.sv =====
// ----------------------------------------------------------------------------
// crv_fifo: two-entry queue
// decouples producer and consumer; full and empty are registered-state flags
// ----------------------------------------------------------------------------
module crv_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("pop did not shrink queue");
  a_push_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("push did not grow queue");

endmodule

// ===== sv/crv_front.sv =====
// ----------------------------------------------------------------------------
// crv_front: request intake
// takes one item, floors a trade time to its bucket with a bit-serial
// remainder unit and hands a command to the back end queue
// ----------------------------------------------------------------------------
module crv_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic                      req_type_i,
  input  logic [crv_pkg::PRICE_W-1:0] trade_price_i,
  input  logic [crv_pkg::TIME_W-1:0]  trade_time_ns_i,
  input  logic [crv_pkg::DUR_W-1:0]   dur_i,
  input  logic                      cmd_full_i,
  output logic                      cmd_push_o,
  output crv_pkg::cmd_t             cmd_o
);
  import crv_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_e;

  fstate_e            state_q;
  cmd_t               cmd_q;
  logic [TIME_W-1:0]  t_q;
  logic [DUR_W-1:0]   rem_q;
  logic [5:0]         bit_q;
  logic [DUR_W:0]     rem_sh;
  logic [DUR_W-1:0]   rem_d;

  assign full_o     = (state_q != F_IDLE);
  assign cmd_push_o = (state_q == F_PUSH);
  assign cmd_o      = cmd_q;

  // one quotient bit per cycle, only the remainder is kept
  assign rem_sh = {rem_q, t_q[bit_q]};
  assign rem_d  = (rem_sh >= {1'b0, dur_i}) ? DUR_W'(rem_sh - {1'b0, dur_i})
                                            : rem_sh[DUR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cmd_q   <= '0;
      t_q     <= '0;
      rem_q   <= '0;
      bit_q   <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (push_i) begin
            cmd_q.evaluate <= req_type_i;
            cmd_q.price    <= (trade_price_i == '0) ? PRICE_W'(1) : trade_price_i;
            t_q            <= trade_time_ns_i;
            rem_q          <= '0;
            bit_q          <= 6'(TIME_W - 1);
            state_q        <= (req_type_i == REQ_EVAL) ? F_PUSH : F_DIV;
          end
        end
        F_DIV: begin
          rem_q <= rem_d;
          bit_q <= bit_q - 6'd1;
          if (bit_q == '0) begin
            cmd_q.start <= t_q - {23'b0, rem_d};
            state_q     <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!cmd_full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  a_start_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push_o && cmd_q.evaluate == REQ_TRADE) |-> (cmd_q.start <= t_q))
    else $error("bucket start past trade time");
  a_rem_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_PUSH && cmd_q.evaluate == REQ_TRADE) |-> (rem_q < dur_i))
    else $error("remainder not below duration");
  a_price_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_o |-> (cmd_q.price != '0)) else $error("zero price reached queue");

endmodule

// ===== sv/crv_log2.sv =====
// ----------------------------------------------------------------------------
// crv_log2: fixed-point base-2 logarithm
// integer part from the leading one, 20 fraction bits by repeated squaring
// of the normalized mantissa, one bit per cycle
// ----------------------------------------------------------------------------
module crv_log2 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [crv_pkg::PRICE_W-1:0] x_i,
  output logic                      busy_o,
  output logic [crv_pkg::LOG_W-1:0]   y_o
);
  import crv_pkg::*;

  logic                 busy_q;
  logic [4:0]           k_q;
  logic [LOG_FRAC-1:0]  frac_q;
  logic [31:0]          m_q;
  logic [4:0]           it_q;
  logic [31:0]          x0;
  logic [4:0]           k0;
  logic [63:0]          sq;
  logic [32:0]          t;

  assign x0 = (x_i == '0) ? 32'd1 : x_i;

  always_comb begin
    k0 = '0;
    for (int i = 0; i < 32; i++) begin
      if (x0[i]) k0 = 5'(i);
    end
  end

  assign sq     = {32'b0, m_q} * {32'b0, m_q};
  assign t      = sq[63:31];
  assign busy_o = busy_q;
  assign y_o    = {k_q, frac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      frac_q <= '0;
      m_q    <= '0;
      it_q   <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      k_q    <= k0;
      frac_q <= '0;
      m_q    <= x0 << (5'd31 - k0);
      it_q   <= '0;
    end else if (busy_q) begin
      frac_q <= {frac_q[LOG_FRAC-2:0], t[32]};
      m_q    <= t[32] ? t[32:1] : t[31:0];
      it_q   <= it_q + 5'd1;
      if (it_q == 5'(LOG_FRAC - 1)) busy_q <= 1'b0;
    end
  end

endmodule

// ===== sv/crv_back.sv =====
// ----------------------------------------------------------------------------
// crv_back: candle ring and volatility engine
// executes queued commands: a new candle or a read-modify-write of the newest one for trades,
// a sweep over the ring with log, square, multiply, divide and square root
// for evaluations
// ----------------------------------------------------------------------------
module crv_back #(
  parameter int unsigned MAX_CANDLES = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic [crv_pkg::DUR_W-1:0]   dur_i,
  input  logic [$clog2(MAX_CANDLES+1)-1:0] cap_i,
  input  logic                      cmd_empty_i,
  input  crv_pkg::cmd_t             cmd_i,
  output logic                      cmd_pop_o,
  input  logic                      res_full_i,
  output logic                      res_push_o,
  output crv_pkg::res_t             res_o
);
  import crv_pkg::*;

  localparam int unsigned SW = $clog2(MAX_CANDLES);
  localparam int unsigned CW = $clog2(MAX_CANDLES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TCMP, S_EFIRST, S_EPAIR, S_ELOG, S_ESQ,
    S_MUL, S_DIV, S_SQINIT, S_SQRT, S_OUT
  } bstate_e;

  // candle store
  logic [PRICE_W-1:0] hi_mem [MAX_CANDLES];
  logic [PRICE_W-1:0] lo_mem [MAX_CANDLES];
  logic [TIME_W-1:0]  st_mem [MAX_CANDLES];
  logic [SW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic [PRICE_W-1:0] wr_hi, wr_lo, rd_hi_q, rd_lo_q;
  logic [TIME_W-1:0]  wr_st, rd_st_q;

  bstate_e            state_q;
  cmd_t               cmd_q;
  res_t               res_q;
  logic [SW-1:0]      ns_q, idx_q;
  logic [CW-1:0]      fill_q, pairs_q;
  logic [PRICE_W-1:0] cur_hi_q, cur_lo_q;
  logic [TIME_W-1:0]  cur_st_q;
  logic [LOG_W-1:0]   l_q;
  logic [57:0]        s2_q;
  logic [63:0]        dsum_q, d_q, rem_q;
  logic [127:0]       n_q;
  logic [6:0]         cnt_q;
  logic [63:0]        v_q, sres_q, sbit_q;

  logic [SW-1:0]      cap_m1, idx_inc, ns_dec;
  logic               is_new, is_old;
  logic [PRICE_W-1:0] pair_hi, pair_lo;
  logic [63:0]        span;
  logic [64:0]        dsum_sum;
  logic               log_start, busy_h, busy_l;
  logic [LOG_W-1:0]   y_h, y_l;
  logic [31:0]        pa, pb;
  logic [63:0]        pp;
  logic [127:0]       pp_sh;
  logic [63:0]        div_sh, div_sub;
  logic               div_take;
  logic [63:0]        sq_try;
  logic               sq_take;
  logic [63:0]        sres_d;

  assign cap_m1  = SW'(cap_i - CW'(1));
  assign idx_inc = (idx_q == cap_m1) ? '0 : idx_q + SW'(1);
  assign ns_dec  = (ns_q == '0) ? cap_m1 : ns_q - SW'(1);

  assign is_new = (fill_q == '0) || (cmd_q.start > rd_st_q);
  assign is_old = !is_new && (cmd_q.start < rd_st_q);

  always_comb begin
    rd_addr = ns_q;
    if (state_q == S_EFIRST || state_q == S_ESQ) rd_addr = idx_inc;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ns_q;
    wr_hi   = cmd_q.price;
    wr_lo   = cmd_q.price;
    wr_st   = cmd_q.start;
    if (state_q == S_TCMP) begin
      if (is_new) begin
        wr_en   = 1'b1;
        wr_addr = ns_dec;
      end else if (!is_old) begin
        wr_en = 1'b1;
        wr_hi = (cmd_q.price > rd_hi_q) ? cmd_q.price : rd_hi_q;
        wr_lo = (cmd_q.price < rd_lo_q) ? cmd_q.price : rd_lo_q;
        wr_st = rd_st_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hi_mem[wr_addr] <= wr_hi;
      lo_mem[wr_addr] <= wr_lo;
      st_mem[wr_addr] <= wr_st;
    end
    rd_hi_q <= hi_mem[rd_addr];
    rd_lo_q <= lo_mem[rd_addr];
    rd_st_q <= st_mem[rd_addr];
  end

  // pair of adjacent candles: newer one held in cur, older one on read data
  assign pair_hi   = (cur_hi_q > rd_hi_q) ? cur_hi_q : rd_hi_q;
  assign pair_lo   = (cur_lo_q < rd_lo_q) ? cur_lo_q : rd_lo_q;
  assign span      = (cur_st_q >= rd_st_q)
                   ? ({1'b0, cur_st_q} - {1'b0, rd_st_q} + {24'b0, dur_i})
                   : {24'b0, dur_i};
  assign dsum_sum  = {1'b0, dsum_q} + {1'b0, span};
  assign log_start = (state_q == S_EPAIR);

  crv_log2 u_log_hi (
    .clk_i, .rst_ni, .start_i(log_start), .x_i(pair_hi), .busy_o(busy_h), .y_o(y_h)
  );
  crv_log2 u_log_lo (
    .clk_i, .rst_ni, .start_i(log_start), .x_i(pair_lo), .busy_o(busy_l), .y_o(y_l)
  );

  // 58 x 53 product from four 32 x 32 partial products
  always_comb begin
    pa    = cnt_q[1] ? {6'b0, s2_q[57:32]} : s2_q[31:0];
    pb    = cnt_q[0] ? LN2_NSY_Q[63:32] : LN2_NSY_Q[31:0];
    pp    = {32'b0, pa} * {32'b0, pb};
    case (cnt_q[1:0])
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
  end

  // restoring division, one quotient bit per cycle
  assign div_sh   = {rem_q[62:0], n_q[127]};
  assign div_take = rem_q[63] | (div_sh >= d_q);
  assign div_sub  = div_sh - d_q;

  // bitwise integer square root
  assign sq_try  = sres_q + sbit_q;
  assign sq_take = (v_q >= sq_try);
  assign sres_d  = sq_take ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);

  assign cmd_pop_o  = (state_q == S_IDLE) && !cmd_empty_i;
  assign res_push_o = (state_q == S_OUT) && !res_full_i;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= '0;
      res_q    <= '0;
      ns_q     <= '0;
      fill_q   <= '0;
      idx_q    <= '0;
      pairs_q  <= '0;
      cur_hi_q <= '0;
      cur_lo_q <= '0;
      cur_st_q <= '0;
      l_q      <= '0;
      s2_q     <= '0;
      dsum_q   <= '0;
      d_q      <= '0;
      rem_q    <= '0;
      n_q      <= '0;
      cnt_q    <= '0;
      v_q      <= '0;
      sres_q   <= '0;
      sbit_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (clear_i) begin
            ns_q   <= '0;
            fill_q <= '0;
          end else if (!cmd_empty_i) begin
            cmd_q <= cmd_i;
            if (cmd_i.evaluate == REQ_TRADE) begin
              state_q <= S_TCMP;
            end else if (fill_q < cap_i) begin
              res_q   <= '{status: ST_SHORT, vol: '0};
              state_q <= S_OUT;
            end else begin
              idx_q   <= ns_q;
              pairs_q <= '0;
              s2_q    <= '0;
              dsum_q  <= '0;
              state_q <= S_EFIRST;
            end
          end
        end
        S_TCMP: begin
          if (is_new) begin
            ns_q   <= ns_dec;
            fill_q <= (fill_q < cap_i) ? fill_q + CW'(1) : cap_i;
          end
          res_q   <= '{status: (is_old ? ST_REJECT : ST_TAKEN), vol: '0};
          state_q <= S_OUT;
        end
        S_EFIRST: begin
          cur_hi_q <= rd_hi_q;
          cur_lo_q <= rd_lo_q;
          cur_st_q <= rd_st_q;
          idx_q    <= idx_inc;
          state_q  <= S_EPAIR;
        end
        S_EPAIR: begin
          dsum_q   <= dsum_sum[64] ? '1 : dsum_sum[63:0];
          cur_hi_q <= rd_hi_q;
          cur_lo_q <= rd_lo_q;
          cur_st_q <= rd_st_q;
          state_q  <= S_ELOG;
        end
        S_ELOG: begin
          if (!busy_h && !busy_l) begin
            l_q     <= (y_h > y_l) ? y_h - y_l : '0;
            state_q <= S_ESQ;
          end
        end
        S_ESQ: begin
          s2_q    <= s2_q + {8'b0, {25'b0, l_q} * {25'b0, l_q}};
          pairs_q <= pairs_q + CW'(1);
          if (pairs_q + CW'(1) == cap_i - CW'(1)) begin
            cnt_q   <= '0;
            n_q     <= '0;
            state_q <= S_MUL;
          end else begin
            idx_q   <= idx_inc;
            state_q <= S_EPAIR;
          end
        end
        S_MUL: begin
          n_q <= n_q + pp_sh;
          if (cnt_q == 7'd3) begin
            cnt_q   <= '0;
            rem_q   <= '0;
            d_q     <= (dsum_q == '0) ? 64'd1 : dsum_q;
            state_q <= S_DIV;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        S_DIV: begin
          rem_q <= div_take ? div_sub : div_sh;
          n_q   <= {n_q[126:0], div_take};
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd127) state_q <= S_SQINIT;
        end
        S_SQINIT: begin
          if (n_q[127:72] != '0) begin
            res_q   <= '{status: ST_READY, vol: '1};
            state_q <= S_OUT;
          end else begin
            v_q     <= n_q[71:8];
            sres_q  <= '0;
            sbit_q  <= 64'd1 << 62;
            cnt_q   <= '0;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_take) v_q <= v_q - sq_try;
          sres_q <= sres_d;
          sbit_q <= sbit_q >> 2;
          cnt_q  <= cnt_q + 7'd1;
          if (cnt_q == 7'd31) begin
            res_q   <= '{status: ST_READY, vol: sres_d[31:0]};
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_full_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap_i) else $error("fill count above ring capacity");
  a_slot_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ns_q} < {1'b0, cap_i}) else $error("newest slot outside ring");
  a_vol_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_q.status != ST_READY) |-> (res_q.vol == '0))
    else $error("volatility set on non-ready status");
  a_log_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!busy_h && !busy_l))
    else $error("log unit busy while idle");

endmodule

// ===== sv/candle_range_volatility.sv =====
// ----------------------------------------------------------------------------
// candle_range_volatility: high-low range volatility over time-bucketed candles
// trades are bucketed and merged into a ring of candles; an evaluation returns
// the annualized range volatility as unsigned Q16.16
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------------
//  request   push / full                req_type_i, trade_price_i,
//                                       trade_time_ns_i
//  result    empty / pop                status_o, volatility_o
//  config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  trade: the bit-serial bucket remainder in the front end, then a candle
//    read-modify-write in the back end
//  evaluate: for each candle pair the log unit and the square, then the multiply,
//    the divider and the square root; a too-few-candles answer skips all of these
//  the front end floors the next trade while the back end still works
//  reset empties the ring and restores the register defaults; no clearing pass
//  a full result queue stalls the back end, a full command queue the front end
//
module candle_range_volatility #(
  parameter int unsigned MAX_CANDLES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request queue side
  input  logic                 push,
  output logic                 full,
  input  logic                 req_type_i,
  input  logic [31:0]          trade_price_i,
  input  logic [62:0]          trade_time_ns_i,
  // result queue side
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           status_o,
  output logic [31:0]          volatility_o,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [crv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [crv_pkg::DUR_W-1:0]     cfg_data_i
);
  import crv_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CANDLES + 1);

  logic [DUR_W-1:0] dur_q;
  logic [LB_W-1:0]  lb_q;
  logic             cfg_we, ring_clear;
  logic [DUR_W-1:0] dur_eff;
  logic [LB_W-1:0]  lb_eff;
  logic [8:0]       cap_wide;
  logic [CW-1:0]    cap;

  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t             cmd_in, cmd_out;
  logic             res_push, res_full;
  res_t             res_in, res_out;

  // register file; a known register write empties the ring while the back end idles
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign ring_clear  = cfg_we && (cfg_index_i == CFG_DURATION ||
                                  cfg_index_i == CFG_LOOKBACK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= DUR_RESET;
      lb_q  <= LB_RESET;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_DURATION: dur_q <= cfg_data_i;
        CFG_LOOKBACK: lb_q  <= cfg_data_i[LB_W-1:0];
        default: ;
      endcase
    end
  end

  // zero duration acts as 1 ns, zero lookback as 1 candle
  assign dur_eff  = (dur_q == '0) ? DUR_W'(1) : dur_q;
  assign lb_eff   = (lb_q == '0) ? LB_W'(1) : lb_q;
  // ring holds lookback + 1 candles, limited by the store depth
  assign cap_wide = {4'b0, lb_eff} + 9'd1;
  assign cap      = (cap_wide > 9'(MAX_CANDLES)) ? CW'(MAX_CANDLES) : CW'(cap_wide);

  // front end: intake and bucket flooring
  crv_front u_front (
    .clk_i,
    .rst_ni,
    .push_i          (push),
    .full_o          (full),
    .req_type_i,
    .trade_price_i,
    .trade_time_ns_i,
    .dur_i           (dur_eff),
    .cmd_full_i      (cmd_full),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in)
  );

  // command queue between the two halves
  crv_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
    .clk_i,
    .rst_ni,
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // back end: candle ring and volatility math
  crv_back #(.MAX_CANDLES(MAX_CANDLES)) u_back (
    .clk_i,
    .rst_ni,
    .clear_i     (ring_clear),
    .dur_i       (dur_eff),
    .cap_i       (cap),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue, its head is shown on the result ports
  crv_fifo #(.WIDTH($bits(res_t))) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign status_o     = res_out.status;
  assign volatility_o = res_out.vol;

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_clear |-> (cmd_empty && !full)) else $error("register write while busy");
  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap >= CW'(2)) && (cap <= CW'(MAX_CANDLES))) else $error("ring capacity out of range");
  a_cfg_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && cfg_index_i == CFG_LOOKBACK) |=> (lb_q == $past(cfg_data_i[LB_W-1:0])))
    else $error("lookback write lost");

endmodule
